@@ rtl/core/puct_child_selector_macros.svh @@
`ifndef PUCT_CHILD_SELECTOR_MACROS_SVH
`define PUCT_CHILD_SELECTOR_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define PCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pcs_pkg.sv @@
package pcs_pkg;

  // Field widths
  localparam int PV_W       = 32;
  localparam int VALUE_W    = 16;
  localparam int PRIOR_W    = 16;
  localparam int VISITS_W   = 32;
  localparam int WEIGHT_W   = 24;
  localparam int INDEX_W    = 8;
  localparam int SCORE_W    = 48;

  // Datapath widths
  localparam int ROOT_W     = 24;                 // floor(sqrt(pv * 2^16))
  localparam int RADICAND_W = PV_W + 16;
  localparam int SQREM_W    = ROOT_W + 3;
  localparam int WP_W       = WEIGHT_W + PRIOR_W; // weight * prior
  localparam int PROD_W     = 64;
  localparam int TERM_SHIFT = 24;
  localparam int DIVIDEND_W = PROD_W - TERM_SHIFT;
  localparam int DIVISOR_W  = VISITS_W + 1;
  localparam int ROOT_HALF  = ROOT_W / 2;

  // Iteration counts
  localparam int SQRT_STEPS = ROOT_W;             // one root bit per cycle
  localparam int DIV_STEPS  = DIVIDEND_W / 2;     // two quotient bits per cycle
  localparam int CNT_W      = 5;

  localparam int MAX_EDGES_DEF = 256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(655);
  localparam logic [SCORE_W-1:0]  SCORE_MIN    = {1'b1, {(SCORE_W-1){1'b0}}};

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_step;
    logic finish;
    logic score;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic node_start;
    logic pos_full;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/core/pcs_ctrl.sv @@
`include "puct_child_selector_macros.svh"

module pcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcs_pkg::stat_t stat,
  output pcs_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE, SQRT, MUL1, MUL2, MUL3, DIV, FIN
  } state_t;

  localparam logic [pcs_pkg::CNT_W-1:0] SQRT_LAST = pcs_pkg::CNT_W'(pcs_pkg::SQRT_STEPS - 1);
  localparam logic [pcs_pkg::CNT_W-1:0] DIV_LAST  = pcs_pkg::CNT_W'(pcs_pkg::DIV_STEPS - 1);

  state_t                      state;
  logic [pcs_pkg::CNT_W-1:0]   cnt;
  logic                        score_edge;

  assign in_ready = (state == IDLE);

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load      = in_valid;
      SQRT: cmd.sqrt_step = 1'b1;
      MUL1: cmd.mul1      = 1'b1;
      MUL2: cmd.mul2      = 1'b1;
      MUL3: cmd.mul3      = 1'b1;
      DIV:  cmd.div_step  = 1'b1;
      FIN: begin
        // a node result waits until the output register is free
        cmd.finish = !(stat.last && stat.out_busy);
        cmd.score  = cmd.finish && score_edge;
      end
      default: cmd = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cnt        <= '0;
      score_edge <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            if (stat.node_start) begin
              state      <= SQRT;
              score_edge <= 1'b1;
            end else if (stat.pos_full) begin
              state      <= FIN;
              score_edge <= 1'b0;
            end else begin
              state      <= MUL1;
              score_edge <= 1'b1;
            end
          end
        end
        SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == SQRT_LAST) begin
            cnt   <= '0;
            state <= MUL1;
          end
        end
        MUL1: state <= MUL2;
        MUL2: state <= MUL3;
        MUL3: state <= DIV;
        DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= FIN;
          end
        end
        FIN: begin
          if (cmd.finish) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `PCS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted item did not make the block busy")
  `PCS_ASSERT_NEXT(a_div_to_fin, clk, rst, state == DIV && cnt == DIV_LAST, state == FIN, "divider did not hand over to finish")

endmodule

@@ rtl/core/pcs_datapath.sv @@
`include "puct_child_selector_macros.svh"

module pcs_datapath #(
  parameter int MAX_EDGES = pcs_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcs_pkg::cmd_t                       cmd,
  output pcs_pkg::stat_t                      stat,
  input  logic [pcs_pkg::PV_W-1:0]            parent_visits,
  input  logic signed [pcs_pkg::VALUE_W-1:0]  edge_value,
  input  logic [pcs_pkg::PRIOR_W-1:0]         edge_prior,
  input  logic [pcs_pkg::VISITS_W-1:0]        edge_visits,
  input  logic                                last_edge,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcs_pkg::WEIGHT_W-1:0]        cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcs_pkg::INDEX_W-1:0]         best_index,
  output logic signed [pcs_pkg::SCORE_W-1:0]  best_score
);

  localparam int PW = $clog2(MAX_EDGES + 1);
  localparam int IW = $clog2(MAX_EDGES);
  localparam int RW = pcs_pkg::ROOT_W;
  localparam int DW = pcs_pkg::DIVISOR_W;
  localparam int QW = pcs_pkg::DIVIDEND_W;
  localparam int SW = pcs_pkg::SCORE_W;

  // One restoring divide step: {quotient bit, new remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                           input logic bit_in,
                                           input logic [DW-1:0] dsr);
    logic [DW:0] sh;
    logic        ge;
    logic [DW:0] diff;
    sh   = {rem, bit_in};
    ge   = (sh >= {1'b0, dsr});
    diff = sh - {1'b0, dsr};
    return ge ? {1'b1, diff[DW-1:0]} : {1'b0, sh[DW-1:0]};
  endfunction

  logic [pcs_pkg::WEIGHT_W-1:0]       weight;
  logic                               node_start;
  logic [PW-1:0]                      pos;
  logic signed [SW-1:0]               run_score;
  logic [IW-1:0]                      run_index;
  logic [RW-1:0]                      root;

  logic signed [pcs_pkg::VALUE_W-1:0] value_r;
  logic [pcs_pkg::PRIOR_W-1:0]        prior_r;
  logic [DW-1:0]                      divisor;
  logic                               last_r;
  logic                               first_r;

  logic [pcs_pkg::RADICAND_W-1:0]     sq_x;
  logic [pcs_pkg::SQREM_W-1:0]        sq_rem;
  logic [pcs_pkg::WP_W-1:0]           wp;
  logic [pcs_pkg::PROD_W-1:0]         prod;
  logic [DW-1:0]                      div_rem;
  logic [QW-1:0]                      div_q;

  logic [pcs_pkg::SQREM_W-1:0]        rem4;
  logic [pcs_pkg::SQREM_W-1:0]        trial;
  logic [pcs_pkg::PROD_W-1:0]         prod_sum;
  logic [DW:0]                        step_a;
  logic [DW:0]                        step_b;
  logic signed [SW-1:0]               score_s;
  logic                               take;
  logic signed [SW-1:0]               score_new;
  logic [IW-1:0]                      index_new;

  assign cfg_ready = 1'b1;

  assign stat.node_start = node_start;
  assign stat.pos_full   = (pos >= PW'(MAX_EDGES));
  assign stat.last       = last_r;
  assign stat.out_busy   = out_valid && !out_ready;

  // Square root step: bring down two radicand bits, try 4*root+1
  assign rem4  = {sq_rem[pcs_pkg::SQREM_W-3:0], sq_x[pcs_pkg::RADICAND_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  // High partial product joins the low one
  assign prod_sum = prod + (pcs_pkg::PROD_W'(wp * root[RW-1 -: pcs_pkg::ROOT_HALF])
                            << pcs_pkg::ROOT_HALF);

  // Two divide steps per cycle
  assign step_a = div_step(div_rem, div_q[QW-1], divisor);
  assign step_b = div_step(step_a[DW-1:0], div_q[QW-2], divisor);

  // Score: 2*value + term. term is below 2^40, so the sum never leaves
  // the 48-bit range and the clamp is not needed.
  assign score_s = $signed(SW'(edge_value_ext(value_r)) + {{(SW-QW){1'b0}}, div_q});

  function automatic logic [SW-1:0] edge_value_ext(input logic signed [pcs_pkg::VALUE_W-1:0] v);
    return {{(SW-pcs_pkg::VALUE_W-1){v[pcs_pkg::VALUE_W-1]}}, v, 1'b0};
  endfunction

  // First edge of a node wins outright; later ones must be strictly greater
  assign take      = cmd.score && (first_r || (score_s > run_score));
  assign score_new = take ? score_s : run_score;
  assign index_new = take ? IW'(pos) : run_index;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= pcs_pkg::WEIGHT_RESET;
    end else if (cfg_valid) begin
      weight <= cfg_data;
    end
  end

  // Node state and running best
  always_ff @(posedge clk) begin
    if (rst) begin
      node_start <= 1'b1;
      pos        <= '0;
      run_score  <= pcs_pkg::SCORE_MIN;
      run_index  <= '0;
      root       <= '0;
    end else begin
      if (cmd.load && node_start) begin
        node_start <= 1'b0;
        pos        <= '0;
        run_score  <= pcs_pkg::SCORE_MIN;
        run_index  <= '0;
        root       <= '0;
      end
      if (cmd.sqrt_step) begin
        root <= {root[RW-2:0], (rem4 >= trial)};
      end
      if (cmd.finish) begin
        if (last_r) begin
          node_start <= 1'b1;
          pos        <= '0;
          run_score  <= pcs_pkg::SCORE_MIN;
          run_index  <= '0;
        end else begin
          run_score <= score_new;
          run_index <= index_new;
          if (cmd.score) pos <= pos + 1'b1;
        end
      end
    end
  end

  // Item capture and arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= edge_value;
      prior_r <= edge_prior;
      divisor <= DW'(edge_visits) + 1'b1;
      last_r  <= last_edge;
      first_r <= node_start;
      sq_x    <= {parent_visits, 16'b0};
      sq_rem  <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_x   <= sq_x << 2;
      sq_rem <= (rem4 >= trial) ? (rem4 - trial) : rem4;
    end
    if (cmd.mul1) wp <= weight * prior_r;
    if (cmd.mul2) prod <= pcs_pkg::PROD_W'(wp * root[pcs_pkg::ROOT_HALF-1:0]);
    if (cmd.mul3) begin
      div_q   <= prod_sum[pcs_pkg::PROD_W-1 -: QW];
      div_rem <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= step_b[DW-1:0];
      div_q   <= {div_q[QW-3:0], step_a[DW], step_b[DW]};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.finish && last_r) || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_r) begin
      best_index <= pcs_pkg::INDEX_W'(index_new);
      best_score <= score_new;
    end
  end

  `PCS_ASSERT_NEXT(a_emit_sets_valid, clk, rst, cmd.finish && last_r, out_valid && node_start, "node end did not post a result")
  `PCS_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.finish && last_r, !(out_valid && !out_ready), "result would overwrite a waiting one")
  `PCS_ASSERT_IMPL(a_pos_range, clk, rst, 1'b1, pos <= PW'(MAX_EDGES), "edge position beyond limit")
  `PCS_ASSERT_IMPL(a_first_scored, clk, rst, cmd.finish && first_r, cmd.score, "first edge of a node was not scored")

endmodule

@@ rtl/core/puct_child_selector.sv @@
// Channel  Signals                                             Dir
// in       in_valid/in_ready, parent_visits, edge_value,       sink
//          edge_prior, edge_visits, last_edge
// out      out_valid/out_ready, best_index, best_score         source
// cfg      cfg_valid/cfg_ready, exploration_weight             sink
//
// Per edge: accept, multiply states MUL1, MUL2 and MUL3, divider steps at
// two quotient bits each, then finish; the first edge of a node adds the
// bit-serial square root. Edges past MAX_EDGES skip to finish unscored.
// One edge is in work at a time; the result register frees the input side
// while a node result waits. A node end stalls only if the previous result
// has not been taken. Reset (rst, synchronous) clears node state and sets
// the weight to its default; cfg_ready is always high.
module puct_child_selector #(
  parameter int MAX_EDGES = pcs_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pcs_pkg::PV_W-1:0]            parent_visits,
  input  logic signed [pcs_pkg::VALUE_W-1:0]  edge_value,
  input  logic [pcs_pkg::PRIOR_W-1:0]         edge_prior,
  input  logic [pcs_pkg::VISITS_W-1:0]        edge_visits,
  input  logic                                last_edge,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcs_pkg::INDEX_W-1:0]         best_index,
  output logic signed [pcs_pkg::SCORE_W-1:0]  best_score,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcs_pkg::WEIGHT_W-1:0]        exploration_weight
);

  pcs_pkg::cmd_t  cmd;
  pcs_pkg::stat_t stat;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcs_datapath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .parent_visits (parent_visits),
    .edge_value    (edge_value),
    .edge_prior    (edge_prior),
    .edge_visits   (edge_visits),
    .last_edge     (last_edge),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (exploration_weight),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .best_index    (best_index),
    .best_score    (best_score)
  );

endmodule
